// File: rtl/core/lmlf_pkg.sv
// Package for the LCD matrix latch and fade block.
// Holds the item kinds, control codes, grid constants and the command struct.
// No dependencies.
package lmlf_pkg;

   localparam int GRID_SIZE   = 16;
   localparam int LATCH_SLOTS = 8;
   localparam int PIXELS      = GRID_SIZE * GRID_SIZE;
   localparam int POS_W       = $clog2(GRID_SIZE);
   localparam int ADDR_W      = $clog2(PIXELS);
   localparam int SLOT_W      = $clog2(LATCH_SLOTS);
   localparam int LEVEL_W     = 4;
   localparam int NIBBLE_W    = 4;
   localparam int MASK_W      = GRID_SIZE;

   localparam logic [1:0] KIND_BUS_WRITE = 2'd0;
   localparam logic [1:0] KIND_VBLANK    = 2'd1;
   localparam logic [1:0] KIND_READ      = 2'd2;

   localparam logic [1:0] CTRL_IDLE   = 2'd0;
   localparam logic [1:0] CTRL_LOAD   = 2'd2;
   localparam logic [1:0] CTRL_STROBE = 2'd3;

   typedef struct packed {
      logic              start_fade;
      logic              start_strobe;
      logic              start_read;
      logic [ADDR_W-1:0] addr;
   } cmd_type;

   typedef struct packed {
      logic               load;
      logic [LEVEL_W-1:0] level;
   } result_type;

endpackage

// File: rtl/core/lcd_matrix_latch_fade.sv
// Top level of the LCD matrix latch and fade block.
// Uses lmlf_pkg, lmlf_latch and lmlf_sweep (which holds the pixel RAM).
//
//  channel  ports                                  direction
//  req      req_valid req_stall req_kind req_control
//           req_nibble req_read_row req_read_col   in (stall out)
//  rsp      rsp_valid rsp_stall rsp_pixel_level    out (stall in)
//
// A bus write that only loads the latch does not stall; one that strobes
// sweeps the pixel RAM, one pixel per cycle. A vblank tick sweeps it too, the
// write port trailing the read port by one pixel. A pixel read holds in the
// sweep unit until the result register is free. Reset is synchronous; valid
// bits clear all pixels to dark.
module lcd_matrix_latch_fade #(
   parameter int FULL_LEVEL = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [1:0]                    req_control,
   input  logic [lmlf_pkg::NIBBLE_W-1:0] req_nibble,
   input  logic [lmlf_pkg::POS_W-1:0]    req_read_row,
   input  logic [lmlf_pkg::POS_W-1:0]    req_read_col,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lmlf_pkg::LEVEL_W-1:0]  rsp_pixel_level
);
   import lmlf_pkg::*;

   logic               busy;
   logic               req_xfer;
   logic               bus_wr;
   logic               strobe_hit;
   logic [MASK_W-1:0]  row_mask;
   logic [MASK_W-1:0]  col_mask;
   logic               rsp_free;
   cmd_type            cmd;
   result_type         res;
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;

   assign req_stall = busy;
   assign req_xfer  = req_valid && !busy;
   assign bus_wr    = req_xfer && (req_kind == KIND_BUS_WRITE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign cmd.start_strobe = strobe_hit;
   assign cmd.start_fade   = req_xfer && (req_kind == KIND_VBLANK);
   assign cmd.start_read   = req_xfer && (req_kind == KIND_READ);
   assign cmd.addr         = {req_read_row, req_read_col};

   lmlf_latch u_latch (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (bus_wr),
      .control    (req_control),
      .nibble     (req_nibble),
      .strobe_hit (strobe_hit),
      .row_mask   (row_mask),
      .col_mask   (col_mask)
   );

   lmlf_sweep #(
      .FULL_LEVEL (FULL_LEVEL)
   ) u_sweep (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .row_mask (row_mask),
      .col_mask (col_mask),
      .rsp_free (rsp_free),
      .busy     (busy),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.load) begin
         rsp_level_ff <= res.level;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_level = rsp_level_ff;

endmodule

// File: rtl/core/lmlf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmlf_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lmlf_latch.sv
// Nibble latch, slot index and control edge detection.
// Uses lmlf_pkg; builds the row and column masks for the strobe sweep.
module lmlf_latch (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [1:0]                     control,
   input  logic [lmlf_pkg::NIBBLE_W-1:0]  nibble,
   output logic                           strobe_hit,
   output logic [lmlf_pkg::MASK_W-1:0]    row_mask,
   output logic [lmlf_pkg::MASK_W-1:0]    col_mask
);
   import lmlf_pkg::*;

   logic [NIBBLE_W-1:0] latch_ff [LATCH_SLOTS];
   logic [SLOT_W-1:0]   slot_ff;
   logic [1:0]          prev_ctrl_ff;
   logic                load_hit;

   assign load_hit   = wr_en && (control == CTRL_LOAD) && (prev_ctrl_ff == CTRL_IDLE);
   assign strobe_hit = wr_en && (control == CTRL_STROBE) && (prev_ctrl_ff == CTRL_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         prev_ctrl_ff <= CTRL_IDLE;
         for (int i = 0; i < LATCH_SLOTS; i++) begin
            latch_ff[i] <= '0;
         end
      end else if (wr_en) begin
         prev_ctrl_ff <= control;
         if (load_hit) begin
            latch_ff[slot_ff] <= nibble;
            slot_ff           <= slot_ff + 1'b1;
         end else if (strobe_hit) begin
            slot_ff <= '0;
         end
      end
   end

   assign row_mask = {latch_ff[0], latch_ff[1], latch_ff[2], latch_ff[3]};
   assign col_mask = {latch_ff[4], latch_ff[5], latch_ff[6], latch_ff[7]};

endmodule

// File: rtl/core/lmlf_sweep.sv
// Sweep sequencer over the pixel RAM: strobe fill, vblank fade and pixel read.
// Uses lmlf_pkg and lmlf_ram; valid bits make unwritten pixels read as dark.
module lmlf_sweep #(
   parameter int FULL_LEVEL = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lmlf_pkg::cmd_type            cmd,
   input  logic [lmlf_pkg::MASK_W-1:0]  row_mask,
   input  logic [lmlf_pkg::MASK_W-1:0]  col_mask,
   input  logic                         rsp_free,
   output logic                         busy,
   output lmlf_pkg::result_type         res
);
   import lmlf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STROBE,
      ST_FADE,
      ST_FADE_TAIL,
      ST_RD_DATA
   } state_type;

   state_type          state_ff;
   logic [ADDR_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0]  wa_ff;
   logic [ADDR_W-1:0]  rd_idx_ff;
   logic               pend_ff;
   logic [PIXELS-1:0]  valid_ff;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [LEVEL_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [LEVEL_W-1:0] ram_rd_data;
   logic               strobe_bit;
   logic               fade_wr;
   logic [POS_W-1:0]   cnt_row;
   logic [POS_W-1:0]   cnt_col;

   assign cnt_row    = cnt_ff[ADDR_W-1:POS_W];
   assign cnt_col    = cnt_ff[POS_W-1:0];
   assign strobe_bit = row_mask[~cnt_row] && col_mask[~cnt_col];
   assign fade_wr    = pend_ff && valid_ff[wa_ff] && (ram_rd_data != '0);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wa_ff;
      ram_wr_data = ram_rd_data - 1'b1;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cnt_ff;
      res.load    = 1'b0;
      res.level   = valid_ff[rd_idx_ff] ? ram_rd_data : '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_read) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cmd.addr;
            end
         end
         ST_STROBE: begin
            ram_wr_en   = strobe_bit;
            ram_wr_addr = cnt_ff;
            ram_wr_data = LEVEL_W'(FULL_LEVEL);
         end
         ST_FADE: begin
            ram_rd_en = 1'b1;
            ram_wr_en = fade_wr;
         end
         ST_FADE_TAIL: begin
            ram_wr_en = fade_wr;
         end
         ST_RD_DATA: begin
            res.load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         wa_ff     <= '0;
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
         valid_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               cnt_ff  <= '0;
               pend_ff <= 1'b0;
               if (cmd.start_strobe) begin
                  state_ff <= ST_STROBE;
               end else if (cmd.start_fade) begin
                  state_ff <= ST_FADE;
               end else if (cmd.start_read) begin
                  rd_idx_ff <= cmd.addr;
                  state_ff  <= ST_RD_DATA;
               end
            end
            ST_STROBE: begin
               if (strobe_bit) begin
                  valid_ff[cnt_ff] <= 1'b1;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_FADE: begin
               pend_ff <= 1'b1;
               wa_ff   <= cnt_ff;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == '1) begin
                  state_ff <= ST_FADE_TAIL;
               end
            end
            ST_FADE_TAIL: begin
               pend_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
            ST_RD_DATA: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);

   lmlf_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (PIXELS)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// File: sim/tb_lcd_matrix_latch_fade.sv
// Self-checking testbench for lcd_matrix_latch_fade: directed and random transfers
// checked against an in-bench model of the latch, strobe and fade behavior.
// Depends on lmlf_pkg and the lcd_matrix_latch_fade RTL.
module tb_lcd_matrix_latch_fade;
   timeunit 1ns;
   timeprecision 1ps;

   import lmlf_pkg::*;

   localparam int FULL_LEVEL = 15;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] CTRL_SPARE  = 2'd1;
   localparam int PHASE_LEN = 64;
   localparam int ITEM_TARGET = 500;

   typedef struct packed {
      logic [1:0]          kind;
      logic [1:0]          control;
      logic [NIBBLE_W-1:0] nibble;
      logic [POS_W-1:0]    row;
      logic [POS_W-1:0]    col;
   } lcd_item_type;

   typedef enum int {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE
   } idle_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = '0;
   logic [1:0] req_control = '0;
   logic [NIBBLE_W-1:0] req_nibble = '0;
   logic [POS_W-1:0] req_read_row = '0;
   logic [POS_W-1:0] req_read_col = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [LEVEL_W-1:0] rsp_pixel_level;

   lcd_item_type pending_items[$];
   logic [LEVEL_W-1:0] expected_levels[$];
   int unsigned queued = 0;
   int unsigned accepted = 0;
   int unsigned mismatches = 0;

   logic [LEVEL_W-1:0]  panel_level [PIXELS];
   logic [NIBBLE_W-1:0] latch_nibbles [LATCH_SLOTS];
   logic [SLOT_W-1:0]   next_slot;
   logic [1:0]          last_control;

   lcd_matrix_latch_fade #(.FULL_LEVEL(FULL_LEVEL)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_control     (req_control),
      .req_nibble      (req_nibble),
      .req_read_row    (req_read_row),
      .req_read_col    (req_read_col),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_level (rsp_pixel_level)
   );

   always #10 clock = ~clock;

   function automatic int idle_pct(input int unsigned count, input bit receiver);
      idle_phase_type phase;
      phase = idle_phase_type'((count / PHASE_LEN) % 4);
      case (phase)
         PH_SENDER_IDLE:    return receiver ? 0 : 58;
         PH_RECEIVER_STALL: return receiver ? 58 : 0;
         PH_BOTH_IDLE:      return 13;
         default:           return 0;
      endcase
   endfunction

   task automatic queue_item(input int unsigned kind, input int unsigned control,
                             input int unsigned nibble,
                             input int unsigned row, input int unsigned col);
      lcd_item_type it;
      it.kind = 2'(kind);
      it.control = 2'(control);
      it.nibble = NIBBLE_W'(nibble);
      it.row = POS_W'(row);
      it.col = POS_W'(col);
      pending_items.push_back(it);
      queued++;
   endtask

   task automatic queue_store(input int unsigned nibble);
      queue_item(KIND_BUS_WRITE, CTRL_IDLE, $urandom, $urandom, $urandom);
      queue_item(KIND_BUS_WRITE, CTRL_LOAD, nibble, $urandom, $urandom);
   endtask

   task automatic update_panel(input lcd_item_type it);
      logic [MASK_W-1:0] rows;
      logic [MASK_W-1:0] cols;
      rows = {latch_nibbles[0], latch_nibbles[1], latch_nibbles[2], latch_nibbles[3]};
      cols = {latch_nibbles[4], latch_nibbles[5], latch_nibbles[6], latch_nibbles[7]};
      case (it.kind)
         KIND_BUS_WRITE: begin
            if (it.control == CTRL_LOAD && last_control == CTRL_IDLE) begin
               latch_nibbles[next_slot] = it.nibble;
               next_slot = next_slot + 1'b1;
            end else if (it.control == CTRL_STROBE && last_control == CTRL_LOAD) begin
               next_slot = '0;
               for (int r = 0; r < GRID_SIZE; r++)
                  for (int c = 0; c < GRID_SIZE; c++)
                     if (rows[GRID_SIZE-1-r] && cols[GRID_SIZE-1-c])
                        panel_level[r*GRID_SIZE+c] = LEVEL_W'(FULL_LEVEL);
            end
            last_control = it.control;
         end
         KIND_VBLANK: begin
            for (int k = 0; k < PIXELS; k++)
               if (panel_level[k] != '0)
                  panel_level[k] = panel_level[k] - 1'b1;
         end
         KIND_READ: expected_levels.push_back(panel_level[{it.row, it.col}]);
         default: ;
      endcase
   endtask

   // driver: advance to the next pending item once the current one transfers
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            update_panel('{req_kind, req_control, req_nibble, req_read_row, req_read_col});
            accepted <= accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(accepted, 1'b0)) begin
               lcd_item_type it;
               it = pending_items.pop_front();
               req_kind <= it.kind;
               req_control <= it.control;
               req_nibble <= it.nibble;
               req_read_row <= it.row;
               req_read_col <= it.col;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each transferred level against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $error("pixel_level: no read pending, got %0d", rsp_pixel_level);
               mismatches++;
            end else begin
               logic [LEVEL_W-1:0] want;
               want = expected_levels.pop_front();
               if (rsp_pixel_level !== want) begin
                  $error("pixel_level: expected %0d, got %0d", want, rsp_pixel_level);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < idle_pct(accepted, 1'b1));
      end
   end

   initial begin
      int stores;
      for (int k = 0; k < PIXELS; k++)
         panel_level[k] = '0;
      for (int k = 0; k < LATCH_SLOTS; k++)
         latch_nibbles[k] = '0;
      next_slot = '0;
      last_control = CTRL_IDLE;

      // directed: dark panel, ignored kind, stray control changes, slot wrap, strobe
      queue_item(KIND_READ, $urandom, $urandom, 0, 0);
      queue_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
      queue_item(KIND_BUS_WRITE, CTRL_SPARE, 15, $urandom, $urandom);
      queue_item(KIND_BUS_WRITE, CTRL_LOAD, 15, $urandom, $urandom);
      queue_store(3);
      queue_store(0);
      queue_store(0);
      queue_store(1);
      queue_store(8);
      queue_store(0);
      queue_store(0);
      queue_store(1);
      queue_store(8);
      queue_item(KIND_BUS_WRITE, CTRL_STROBE, $urandom, $urandom, $urandom);
      queue_item(KIND_READ, $urandom, $urandom, 0, 0);
      queue_item(KIND_READ, $urandom, $urandom, 15, 15);
      queue_item(KIND_READ, $urandom, $urandom, 2, 0);
      queue_item(KIND_VBLANK, $urandom, $urandom, $urandom, $urandom);
      queue_item(KIND_READ, $urandom, $urandom, 0, 15);

      // random: mostly full latch frames with reads and fades, some noise
      while (queued < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 75) begin
            stores = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : LATCH_SLOTS;
            repeat (stores) queue_store($urandom);
            queue_item(KIND_BUS_WRITE, CTRL_STROBE, $urandom, $urandom, $urandom);
            repeat ($urandom_range(2, 8))
               queue_item(($urandom_range(0, 2) == 0) ? KIND_VBLANK : KIND_READ,
                          $urandom, $urandom, $urandom, $urandom);
         end else begin
            repeat ($urandom_range(1, 4))
               queue_item($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_levels.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);

      if (expected_levels.size() != 0) begin
         $error("pixel_level: %0d reads never returned", expected_levels.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $error("timeout with %0d items pending", pending_items.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
